FILE: hdl/pmbf_pkg.sv
// ----------------------------------------------------------------------------
// pmbf_pkg
// Shared types and constants for the pair membership bit filter.
// ----------------------------------------------------------------------------
package pmbf_pkg;

  localparam int TABLE_BYTES_DEF = 4096;

  localparam int NODE_W = 31;
  localparam int WORD_W = 32;
  localparam int BYTE_W = 8;
  localparam int CNT_W  = 32;

  // table_length register
  localparam int              LEN_W     = 13;
  localparam logic [LEN_W-1:0] LEN_RESET = 13'd4096;

  // hash multipliers
  localparam int MULT_BYTE = 113;
  localparam int MULT_BIT  = 37;

  // len / 113 by reciprocal; exact for every 13-bit len
  localparam int RECIP_113   = 9280;
  localparam int RECIP_W     = 14;
  localparam int RECIP_SHIFT = 20;
  localparam int Q_W         = 7;

  // modulo reducer: 2*RED_HALF compare/subtract steps, RED_HALF per cycle
  localparam int RED_HALF = 5;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [WORD_W-1:0] hi;
    logic [WORD_W-1:0] lo;
  } pmbf_item_t;

  typedef struct packed {
    logic       valid;
    pmbf_item_t item;
  } pmbf_push_t;

endpackage

FILE: hdl/pair_membership_bit_filter.sv
// ----------------------------------------------------------------------------
// pair_membership_bit_filter
// Single-hash bit filter over unordered node pairs. A request is taken on
// start while busy is low and goes into a two-entry queue, so start can be
// taken while the engine works. In the engine each request is loaded, then
// hashed to a byte address over the pair bytes through the shared modulo
// reducer (the bit hash runs alongside), then gets one store read and one
// read-modify-write. The first request after reset or after a table_length
// write first sets up the modulus. After reset busy stays high while the
// store is cleared. Each result is shown for one cycle with done; there is
// no backpressure, so the receiver must take it then. Write table_length
// only while idle.
// ----------------------------------------------------------------------------
module pair_membership_bit_filter #(
  parameter int TABLE_BYTES = pmbf_pkg::TABLE_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [pmbf_pkg::NODE_W-1:0] node_a,
  input  logic [pmbf_pkg::NODE_W-1:0] node_b,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [pmbf_pkg::LEN_W-1:0]  cfg_data,
  output logic                        done,
  output logic                        already_present,
  output logic [pmbf_pkg::CNT_W-1:0]  collision_count
);
  import pmbf_pkg::*;

  localparam int AW = $clog2(TABLE_BYTES);

  logic [LEN_W-1:0]  table_length;
  logic              cfg_we;
  pmbf_push_t        push;
  pmbf_item_t        q_item;
  logic              q_empty;
  logic              q_full;
  logic              q_pop;
  logic              clearing;
  logic              ram_wr_en;
  logic [AW-1:0]     ram_wr_addr;
  logic [BYTE_W-1:0] ram_wr_data;
  logic              ram_rd_en;
  logic [AW-1:0]     ram_rd_addr;
  logic [BYTE_W-1:0] ram_rd_data;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_length <= LEN_RESET;
    end else if (cfg_we) begin
      table_length <= cfg_data;
    end
  end

  pmbf_front u_front (
    .start    (start),
    .node_a   (node_a),
    .node_b   (node_b),
    .q_full   (q_full),
    .clearing (clearing),
    .busy     (busy),
    .push     (push)
  );

  pmbf_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (q_pop),
    .item  (q_item),
    .empty (q_empty),
    .full  (q_full)
  );

  pmbf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (TABLE_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  pmbf_back #(
    .TABLE_BYTES (TABLE_BYTES)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .table_length    (table_length),
    .cfg_we          (cfg_we),
    .q_empty         (q_empty),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .ram_wr_en       (ram_wr_en),
    .ram_wr_addr     (ram_wr_addr),
    .ram_wr_data     (ram_wr_data),
    .ram_rd_en       (ram_rd_en),
    .ram_rd_addr     (ram_rd_addr),
    .ram_rd_data     (ram_rd_data),
    .clearing        (clearing),
    .done            (done),
    .already_present (already_present),
    .collision_count (collision_count)
  );

`ifndef ASSERT_OFF
  // an accepted request is in the queue on the next cycle
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !q_empty)
    else $error("accepted request did not reach the queue");

  // done strobes never come back to back
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("back-to-back done strobes");

  // store clearing blocks intake right after reset
  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> (busy && clearing))
    else $error("intake open during store clearing");
`endif

endmodule

FILE: hdl/pmbf_ram.sv
// ----------------------------------------------------------------------------
// pmbf_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pmbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/pmbf_front.sv
// ----------------------------------------------------------------------------
// pmbf_front
// Request intake: offsets both node indices by one, orders them larger
// first and pushes the ordered pair into the work queue.
// ----------------------------------------------------------------------------
module pmbf_front (
  input  logic                        start,
  input  logic [pmbf_pkg::NODE_W-1:0] node_a,
  input  logic [pmbf_pkg::NODE_W-1:0] node_b,
  input  logic                        q_full,
  input  logic                        clearing,
  output logic                        busy,
  output pmbf_pkg::pmbf_push_t        push
);
  import pmbf_pkg::*;

  logic [WORD_W-1:0] a_inc;
  logic [WORD_W-1:0] b_inc;
  logic              a_larger;

  assign a_inc    = WORD_W'(node_a) + WORD_W'(1);
  assign b_inc    = WORD_W'(node_b) + WORD_W'(1);
  assign a_larger = a_inc > b_inc;

  assign busy = q_full | clearing;

  always_comb begin
    push.valid   = start & ~busy;
    push.item.hi = a_larger ? a_inc : b_inc;
    push.item.lo = a_larger ? b_inc : a_inc;
  end

endmodule

FILE: hdl/pmbf_queue.sv
// ----------------------------------------------------------------------------
// pmbf_queue
// Short FIFO between request intake and the hash/lookup engine.
// ----------------------------------------------------------------------------
module pmbf_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  pmbf_pkg::pmbf_push_t push,
  input  logic                 pop,
  output pmbf_pkg::pmbf_item_t item,
  output logic                 empty,
  output logic                 full
);
  import pmbf_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_QW-1:0] CNT_FULL = CNT_QW'(QUEUE_DEPTH);

  pmbf_item_t        entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_QW-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign empty   = count == '0;
  assign full    = count == CNT_FULL;
  assign do_push = push.valid & ~full;
  assign do_pop  = pop & ~empty;
  assign item    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_QW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_QW'(1);
      end
    end
  end

endmodule

FILE: hdl/pmbf_back.sv
// ----------------------------------------------------------------------------
// pmbf_back
// Hash and lookup engine: two Horner hashes over the eight pair bytes
// (byte hash through a shared modulo reducer, bit hash mod 8), then a
// read-modify-write of the bit store and the saturating collision count.
// Also runs the store clearing pass after reset.
// ----------------------------------------------------------------------------
module pmbf_back #(
  parameter int TABLE_BYTES = pmbf_pkg::TABLE_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [pmbf_pkg::LEN_W-1:0]     table_length,
  input  logic                           cfg_we,
  input  logic                           q_empty,
  input  pmbf_pkg::pmbf_item_t           q_item,
  output logic                           q_pop,
  output logic                           ram_wr_en,
  output logic [$clog2(TABLE_BYTES)-1:0] ram_wr_addr,
  output logic [pmbf_pkg::BYTE_W-1:0]    ram_wr_data,
  output logic                           ram_rd_en,
  output logic [$clog2(TABLE_BYTES)-1:0] ram_rd_addr,
  input  logic [pmbf_pkg::BYTE_W-1:0]    ram_rd_data,
  output logic                           clearing,
  output logic                           done,
  output logic                           already_present,
  output logic [pmbf_pkg::CNT_W-1:0]     collision_count
);
  import pmbf_pkg::*;

  localparam int AW  = $clog2(TABLE_BYTES);
  localparam int M_W = LEN_W + 1;
  localparam int V_W = M_W + 2 * RED_HALF - 1;
  localparam int P_W = LEN_W + RECIP_W;
  localparam int SR_W = 2 * WORD_W;
  localparam logic [31:0]   TB32      = 32'(TABLE_BYTES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_BYTES - 1);
  localparam logic [2:0]    BIT_MULT  = 3'(MULT_BIT % 8);

  // byte hash steps (8 pair bytes), offset steps (bytes of 0xFFFFFF00)
  localparam logic [2:0] H_LAST    = 3'd7;
  localparam logic [2:0] C_LAST    = 3'd3;
  localparam logic [2:0] C_ZERO_AT = 3'd2;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SETUP = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_RED   = 3'd4;
  localparam logic [2:0] S_READ  = 3'd5;
  localparam logic [2:0] S_CHECK = 3'd6;

  logic [2:0]       state;
  logic [AW-1:0]    clr_addr;
  logic             off_valid;
  logic [LEN_W-1:0] len;
  logic [Q_W-1:0]   quot;
  logic [M_W-1:0]   modulus;
  logic [M_W-1:0]   offset;
  logic [V_W-1:0]   v;
  logic             phase;
  logic             off_mode;
  logic [2:0]       step;
  logic [SR_W-1:0]  sr;
  logic [2:0]       bit_acc;
  logic [AW-1:0]    addr;
  logic [CNT_W-1:0] hits;

  logic [LEN_W-1:0] len_eff;
  logic [P_W-1:0]   prod;
  logic             div_hit;
  logic [V_W-1:0]   v_upper;
  logic [M_W-1:0]   red;
  logic             present;
  logic [CNT_W-1:0] hits_next;
  logic [BYTE_W-1:0] mask;

  // v < 2^(2*RED_HALF) * md on entry; each half strips RED_HALF bits
  function automatic logic [V_W-1:0] red_half(input logic [V_W-1:0] val,
                                              input logic [M_W-1:0] md,
                                              input logic           upper);
    logic [V_W-1:0] r;
    logic [V_W-1:0] sm;
    r = val;
    for (int j = 0; j < RED_HALF; j++) begin
      sm = V_W'(md) << (upper ? (2 * RED_HALF - 1 - j) : (RED_HALF - 1 - j));
      if (r >= sm) begin
        r = r - sm;
      end
    end
    return r;
  endfunction

  // sign-extended byte = 0xFFFFFF00 + b when negative, so add the offset
  function automatic logic [V_W-1:0] raw_hash(input logic [M_W-1:0]    acc,
                                              input logic [BYTE_W-1:0] b,
                                              input logic [M_W-1:0]    off);
    return V_W'(acc) * V_W'(MULT_BYTE) + V_W'(b)
           + (b[BYTE_W-1] ? V_W'(off) : V_W'(0));
  endfunction

  function automatic logic [V_W-1:0] raw_radix(input logic [M_W-1:0]    acc,
                                               input logic [BYTE_W-1:0] b);
    return (V_W'(acc) << BYTE_W) + V_W'(b);
  endfunction

  // bit hash modulus is 8 (37 and 8 do not divide), low 3 bits suffice
  function automatic logic [2:0] bit_step(input logic [2:0]        acc,
                                          input logic [BYTE_W-1:0] b);
    return 3'(acc * BIT_MULT) + b[2:0];
  endfunction

  always_comb begin
    if (table_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(table_length) > TB32) begin
      len_eff = LEN_W'(TABLE_BYTES);
    end else begin
      len_eff = table_length;
    end
  end

  assign prod    = P_W'(len_eff) * P_W'(RECIP_113);
  assign div_hit = (M_W'(quot) * M_W'(MULT_BYTE) == M_W'(len)) || (len == LEN_W'(1));
  assign v_upper = red_half(v, modulus, 1'b1);
  assign red     = M_W'(red_half(v, modulus, 1'b0));

  assign present   = ram_rd_data[bit_acc];
  assign hits_next = (present && hits != '1) ? hits + CNT_W'(1) : hits;
  assign mask      = BYTE_W'(1) << bit_acc;

  assign clearing    = state == S_CLEAR;
  assign q_pop       = (state == S_IDLE) && !q_empty;
  assign ram_rd_en   = state == S_READ;
  assign ram_rd_addr = addr;
  assign ram_wr_en   = clearing || (state == S_CHECK && !present);
  assign ram_wr_addr = clearing ? clr_addr : addr;
  assign ram_wr_data = clearing ? '0 : (ram_rd_data | mask);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      off_valid <= 1'b0;
      hits      <= '0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == LAST_ADDR) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!q_empty) begin
            if (off_valid) begin
              sr       <= {8'd0, q_item.lo, q_item.hi[WORD_W-1:BYTE_W]};
              v        <= raw_hash('0, q_item.hi[BYTE_W-1:0], offset);
              bit_acc  <= bit_step('0, q_item.hi[BYTE_W-1:0]);
              step     <= '0;
              off_mode <= 1'b0;
              phase    <= 1'b0;
              state    <= S_RED;
            end else begin
              sr    <= {q_item.lo, q_item.hi};
              state <= S_SETUP;
            end
          end
        end
        S_SETUP: begin
          len   <= len_eff;
          quot  <= prod[RECIP_SHIFT +: Q_W];
          state <= S_DIV;
        end
        S_DIV: begin
          // modulus bumps by one when len and 113 divide one another
          modulus  <= M_W'(len) + M_W'(div_hit);
          v        <= raw_radix('0, 8'hFF);
          step     <= '0;
          off_mode <= 1'b1;
          phase    <= 1'b0;
          state    <= S_RED;
        end
        S_RED: begin
          if (!phase) begin
            v     <= v_upper;
            phase <= 1'b1;
          end else begin
            phase <= 1'b0;
            if (off_mode) begin
              if (step == C_LAST) begin
                offset    <= red;
                off_valid <= 1'b1;
                off_mode  <= 1'b0;
                v         <= raw_hash('0, sr[BYTE_W-1:0], red);
                bit_acc   <= bit_step('0, sr[BYTE_W-1:0]);
                sr        <= sr >> BYTE_W;
                step      <= '0;
              end else begin
                v    <= raw_radix(red, (step == C_ZERO_AT) ? 8'h00 : 8'hFF);
                step <= step + 3'd1;
              end
            end else begin
              if (step == H_LAST) begin
                // reduced value can equal len only when modulus is len + 1
                addr  <= (red == M_W'(len)) ? '0 : AW'(red);
                state <= S_READ;
              end else begin
                v       <= raw_hash(red, sr[BYTE_W-1:0], offset);
                bit_acc <= bit_step(bit_acc, sr[BYTE_W-1:0]);
                sr      <= sr >> BYTE_W;
                step    <= step + 3'd1;
              end
            end
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          hits            <= hits_next;
          done            <= 1'b1;
          already_present <= present;
          collision_count <= hits_next;
          state           <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (cfg_we) begin
        off_valid <= 1'b0;
      end
    end
  end

endmodule
